// ----- rtl/core/vrlr_pkg.sv -----
// Shared types, constants and lookup tables for the voice ring LED renderer.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package vrlr_pkg;

  localparam int unsigned GridSize   = 5;
  localparam int unsigned PixelCount = GridSize * GridSize;
  localparam int unsigned PixIdxW    = $clog2(PixelCount);
  localparam int unsigned CoordW     = 3;
  localparam int unsigned RadW       = 10;
  localparam int unsigned BrightW    = 16;

  localparam logic [12:0] QuarterSine [17] = '{
    13'd0, 13'd401, 13'd799, 13'd1189, 13'd1567, 13'd1931, 13'd2276, 13'd2598, 13'd2896,
    13'd3166, 13'd3406, 13'd3612, 13'd3784, 13'd3920, 13'd4017, 13'd4076, 13'd4096
  };

  localparam logic [RadW-1:0] CentreDist [PixelCount] = '{
    10'd724, 10'd572, 10'd512, 10'd572, 10'd724,
    10'd572, 10'd362, 10'd256, 10'd362, 10'd572,
    10'd512, 10'd256, 10'd0,   10'd256, 10'd512,
    10'd572, 10'd362, 10'd256, 10'd362, 10'd572,
    10'd724, 10'd572, 10'd512, 10'd572, 10'd724
  };

  typedef struct packed {
    logic [RadW-1:0]    radius;
    logic [BrightW-1:0] bright;
  } frame_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              last;
  } pix_tag_t;

  typedef struct packed {
    logic               valid;
    logic [PixIdxW-1:0] idx;
    pix_tag_t           tag;
    frame_t             frame;
  } pix_req_t;

endpackage

// ----- rtl/core/vrlr_frame_pipe.sv -----
// Seven-stage frame pipeline: breathing phase, sine interpolation, radius and brightness.
// Depends on vrlr_pkg for the quarter-wave sine table and the frame type.
`timescale 1ns / 1ps

module vrlr_frame_pipe #(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      level_i,
  input  logic [31:0]     time_i,
  input  logic            take_i,
  output logic            out_valid_o,
  output vrlr_pkg::frame_t frame_o,
  output logic            busy_o
);
  import vrlr_pkg::*;

  localparam int unsigned IdxW = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned PadW = 24 - IdxW;
  localparam logic [31:0] PhaseStep = 32'd2118871;
  localparam logic [31:0] RadBase = 32'd315384000;
  localparam logic [31:0] RadSlope = 32'd8601600;
  localparam logic [33:0] RadDiv = 34'd4080000;
  localparam logic [20:0] RadRecip = 21'((64'd1 << 42) / 64'd4080000);
  localparam logic [31:0] BrBase = 32'd188010480;
  localparam logic [31:0] BrSlope = 32'd1351680;
  localparam logic [25:0] BrDiv = 26'd255;
  localparam logic [25:0] BrRecip = 26'((64'd1 << 33) / 64'd255);

  logic [6:0] vld_q;
  logic       en;

  logic [7:0]      lvl1_q, lvl2_q, lvl3_q, lvl4_q;
  logic [IdxW-1:0] idx1_q;
  logic [4:0]      e2_q;
  logic [17:0]     frac2_q;
  logic            neg2_q;
  logic signed [13:0] osc3_q;
  logic signed [23:0] mr4_q;
  logic [21:0]     mb4_q;
  logic [31:0]     xr5_q, xr6_q;
  logic [24:0]     xb5_q, xb6_q;
  logic [10:0]     qr6_q;
  logic [15:0]     qb6_q;
  frame_t          frame7_q;

  logic [31:0] phase;
  logic [23:0] pos;
  logic [22:0] qeff;
  logic [4:0]  e_nx;
  logic [12:0] base, delta, mag;
  logic [30:0] iprod;
  logic signed [13:0] osc_d;
  logic [9:0]  rad_w;
  logic [13:0] oscoff;
  logic [7:0]  bri_w;
  logic [31:0] rad_lin;
  logic signed [31:0] rad_osc;
  logic [31:0] xr_d, bsum;
  logic [52:0] pr;
  logic [50:0] pb;
  logic [33:0] rrem;
  logic [25:0] brem;
  frame_t      frame_d;

  assign busy_o = vld_q[6] && !take_i;
  assign en = !busy_o;
  assign out_valid_o = vld_q[6];
  assign frame_o = frame7_q;

  always_comb begin
    phase = time_i * PhaseStep;
    pos = {idx1_q, {PadW{1'b0}}};
    qeff = pos[22] ? (23'h400000 - {1'b0, pos[21:0]}) : {1'b0, pos[21:0]};

    e_nx = (e2_q == 5'd16) ? e2_q : e2_q + 5'd1;
    base = QuarterSine[e2_q];
    delta = QuarterSine[e_nx] - base;
    iprod = 31'(delta) * 31'(frac2_q);
    mag = base + iprod[30:18];
    osc_d = neg2_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    rad_w = 10'd425 - {2'b00, lvl3_q};
    oscoff = $unsigned(osc3_q) + 14'd4096;
    bri_w = 8'd255 - lvl3_q;

    rad_lin = RadBase + 32'(lvl4_q) * RadSlope;
    rad_osc = 32'(mr4_q) * 32'sd78;
    xr_d = rad_lin + $unsigned(rad_osc);
    bsum = BrBase + 32'(lvl4_q) * BrSlope + 32'(mb4_q) * 32'd40;

    pr = 53'(xr5_q) * 53'(RadRecip);
    pb = 51'(xb5_q) * 51'(BrRecip);

    rrem = {2'b00, xr6_q} - 34'(qr6_q) * 34'd4080000;
    brem = {1'b0, xb6_q} - 26'(qb6_q) * BrDiv;
    frame_d.radius = 10'(qr6_q + 11'(rrem >= RadDiv));
    frame_d.bright = qb6_q + 16'(brem >= BrDiv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[5:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lvl1_q   <= level_i;
      idx1_q   <= phase[31 -: IdxW];
      lvl2_q   <= lvl1_q;
      e2_q     <= qeff[22:18];
      frac2_q  <= qeff[17:0];
      neg2_q   <= pos[23];
      lvl3_q   <= lvl2_q;
      osc3_q   <= osc_d;
      lvl4_q   <= lvl3_q;
      mr4_q    <= osc3_q * $signed(rad_w);
      mb4_q    <= 22'(oscoff) * 22'(bri_w);
      xr5_q    <= xr_d;
      xb5_q    <= bsum[29:5];
      xr6_q    <= xr5_q;
      xb6_q    <= xb5_q;
      qr6_q    <= pr[52:42];
      qb6_q    <= pb[48:33];
      frame7_q <= frame_d;
    end
  end

endmodule

// ----- rtl/core/vrlr_pixel_pipe.sv -----
// Four-stage pixel pipeline: centre distance, closeness, square and scaled brightness.
// Depends on vrlr_pkg for the distance table and the request and tag types.
`timescale 1ns / 1ps

module vrlr_pixel_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vrlr_pkg::pix_req_t req_i,
  output logic               valid_o,
  output vrlr_pkg::pix_tag_t tag_o,
  output logic [7:0]         level_o
);
  import vrlr_pkg::*;

  localparam logic [26:0] Div9Recip = 27'd7282;

  logic [3:0] vld_q;
  pix_tag_t   tag2_q, tag3_q, tag4_q, tag5_q;
  logic [BrightW-1:0] bright2_q, bright3_q, bright4_q;
  logic [RadW-1:0]    absd2_q;
  logic [8:0]  close3_q;
  logic [16:0] sq4_q;
  logic [7:0]  level5_q;

  logic [RadW-1:0]   cdist;
  logic signed [10:0] sdiff;
  logic [RadW-1:0]   absd;
  logic [13:0] num;
  logic [26:0] quo;
  logic [8:0]  close_d;
  logic [32:0] lp;
  logic [7:0]  level_d;

  always_comb begin
    cdist = CentreDist[req_i.idx];
    sdiff = $signed({1'b0, cdist}) - $signed({1'b0, req_i.frame.radius});
    absd = sdiff[10] ? 10'(-sdiff) : 10'(sdiff);

    num = 14'(absd2_q) * 14'd10 + 14'd4;
    quo = 27'(num) * Div9Recip;
    close_d = (quo[25:16] >= 10'd256) ? 9'd0 : 9'(10'd256 - quo[25:16]);

    lp = 33'(bright4_q) * 33'(sq4_q);
    level_d = (lp[32:24] > 9'd255) ? 8'd255 : lp[31:24];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    tag2_q    <= req_i.tag;
    bright2_q <= req_i.frame.bright;
    absd2_q   <= absd;
    tag3_q    <= tag2_q;
    bright3_q <= bright2_q;
    close3_q  <= close_d;
    tag4_q    <= tag3_q;
    bright4_q <= bright3_q;
    sq4_q     <= 17'(close3_q) * 17'(close3_q);
    tag5_q    <= tag4_q;
    level5_q  <= level_d;
  end

  assign valid_o = vld_q[3];
  assign tag_o = tag5_q;
  assign level_o = level5_q;

endmodule

// ----- rtl/core/voice_ring_led_renderer.sv -----
// Voice ring LED renderer top level: frame pipeline, pixel sequencer and pixel pipeline.
// An accepted frame leaves the frame pipeline when the sequencer takes it into frame_q;
// its 25 pixels then pass the four pixel stages in consecutive cycles to the outputs.
// The pixel sequencer, at one pixel per cycle, sets throughput. Up to seven further
// frames queue in the frame pipeline. Reset clears all valid bits and the sequencer.
`timescale 1ns / 1ps

module voice_ring_led_renderer #(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  level_norm_i,
  input  logic [31:0] time_ms_i,
  output logic        pixel_valid_o,
  output logic [2:0]  pixel_x_o,
  output logic [2:0]  pixel_y_o,
  output logic [7:0]  pixel_level_o,
  output logic        last_pixel_o
);
  import vrlr_pkg::*;

  logic   f_valid, take, seq_last;
  frame_t f_frame, frame_q;
  logic   act_q;
  logic [PixIdxW-1:0] cnt_q;
  logic [CoordW-1:0]  x_q, y_q;
  pix_req_t req;
  pix_tag_t tag;

  vrlr_frame_pipe #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start_i && !busy_o),
    .level_i    (level_norm_i),
    .time_i     (time_ms_i),
    .take_i     (take),
    .out_valid_o(f_valid),
    .frame_o    (f_frame),
    .busy_o     (busy_o)
  );

  assign seq_last = (cnt_q == PixIdxW'(PixelCount - 1));
  assign take = f_valid && (!act_q || seq_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= '0;
      x_q   <= '0;
      y_q   <= '0;
    end else if (take) begin
      act_q <= 1'b1;
      cnt_q <= '0;
      x_q   <= '0;
      y_q   <= '0;
    end else if (act_q) begin
      if (seq_last) begin
        act_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + PixIdxW'(1);
        if (x_q == CoordW'(GridSize - 1)) begin
          x_q <= '0;
          y_q <= y_q + CoordW'(1);
        end else begin
          x_q <= x_q + CoordW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      frame_q <= f_frame;
    end
  end

  always_comb begin
    req.valid = act_q;
    req.idx = cnt_q;
    req.tag.x = x_q;
    req.tag.y = y_q;
    req.tag.last = seq_last;
    req.frame = frame_q;
  end

  vrlr_pixel_pipe u_pixel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .valid_o(pixel_valid_o),
    .tag_o  (tag),
    .level_o(pixel_level_o)
  );

  assign pixel_x_o = tag.x;
  assign pixel_y_o = tag.y;
  assign last_pixel_o = tag.last;

  a_last_corner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_o && last_pixel_o |->
      pixel_x_o == CoordW'(GridSize - 1) && pixel_y_o == CoordW'(GridSize - 1))
    else $error("last pixel word is not at the far corner");

  a_pixel_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_o |-> $past(act_q, 4))
    else $error("pixel word without a sequencer slot");

  a_seq_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q && !seq_last |=> act_q && cnt_q == $past(cnt_q) + PixIdxW'(1))
    else $error("pixel sequencer skipped or repeated a pixel");

  a_busy_reason : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> f_valid && act_q && !seq_last)
    else $error("busy without a waiting frame");

endmodule

// ----- sim/voice_ring_led_renderer_tb.sv -----
// Self-checking testbench for the voice ring LED renderer: frames go in, 25 pixels come out.
// Depends on vrlr_pkg and voice_ring_led_renderer; a class predicts and checks every pixel.
`timescale 1ns / 1ps

module voice_ring_led_renderer_tb;
  import vrlr_pkg::*;

  localparam int unsigned SineDepth = 256;
  localparam int unsigned RandomFrames = 140;
  localparam int unsigned CalmFrames = 40;

  typedef struct {
    logic [2:0] x;
    logic [2:0] y;
    logic [7:0] level;
    logic       is_last;
  } ring_pixel_t;

  class ring_pixel_board;
    ring_pixel_t pending_pixels[$];
    int unsigned mismatches;
    int unsigned checked_pixels;
    int unsigned frames;

    function automatic longint breath_sine_q12(logic [31:0] tms);
      logic [31:0] phase;
      longint unsigned idx;
      longint unsigned pos;
      logic [1:0] quad;
      int unsigned q;
      int unsigned e;
      int unsigned frac;
      int lo;
      int hi;
      int v;
      phase = tms * 32'd2118871;
      idx = ({32'd0, phase} * 64'(SineDepth)) >> 32;
      pos = (idx << 24) / 64'(SineDepth);
      quad = pos[23:22];
      q = int'(pos[21:0]);
      if (quad[0]) begin
        q = 32'h400000 - q;
      end
      e = q >> 18;
      frac = q & 32'h3FFFF;
      if (e >= 16) begin
        v = 4096;
      end else begin
        lo = int'(QuarterSine[e]);
        hi = int'(QuarterSine[e + 1]);
        v = lo + int'((longint'(hi - lo) * longint'(frac)) / 262144);
      end
      return quad[1] ? -longint'(v) : longint'(v);
    endfunction

    function void note_frame(logic [7:0] lvl_in, logic [31:0] tms);
      longint lvl;
      longint osc;
      longint rden;
      longint bden;
      longint rnum;
      longint bnum;
      longint radius;
      longint bright;
      longint gap;
      longint close;
      longint lev;
      ring_pixel_t px;
      lvl = longint'(lvl_in);
      osc = breath_sine_q12(tms);
      rden = longint'(1000) * 1000 * 255 * 4096;
      bden = longint'(255) * 8192;
      rnum = longint'(300) * 1000 * 255 * 4096 + longint'(2100) * 1000 * 4096 * lvl
           + longint'(130) * osc * (longint'(255000) - 600 * lvl);
      radius = (rnum * 256 + rden / 2) / rden;
      bnum = longint'(90) * 255 * 8192 + longint'(165) * 8192 * lvl
           + longint'(40) * (255 - lvl) * (4096 + osc);
      bright = (bnum * 256 + bden / 2) / bden;
      for (int k = 0; k < 25; k++) begin
        gap = longint'(CentreDist[k]) - radius;
        if (gap < 0) begin
          gap = -gap;
        end
        close = 256 - (gap * 10 + 4) / 9;
        if (close < 0) begin
          close = 0;
        end
        lev = (bright * close * close) / 16777216;
        if (lev > 255) begin
          lev = 255;
        end
        px.x = 3'(k % 5);
        px.y = 3'(k / 5);
        px.level = 8'(lev);
        px.is_last = (k == 24);
        pending_pixels.push_back(px);
      end
      frames++;
    endfunction

    function void check_pixel(logic [2:0] x, logic [2:0] y, logic [7:0] lev, logic is_last);
      ring_pixel_t want;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected pixel x=%0d y=%0d level=%0d last=%0d", x, y, lev, is_last);
        end
        return;
      end
      want = pending_pixels.pop_front();
      checked_pixels++;
      if (x !== want.x || y !== want.y || lev !== want.level || is_last !== want.is_last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: want x=%0d y=%0d lvl=%0d last=%0d, got x=%0d y=%0d lvl=%0d last=%0d",
                   want.x, want.y, want.level, want.is_last, x, y, lev, is_last);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [7:0]  level_norm_i;
  logic [31:0] time_ms_i;
  logic        pixel_valid_o;
  logic [2:0]  pixel_x_o;
  logic [2:0]  pixel_y_o;
  logic [7:0]  pixel_level_o;
  logic        last_pixel_o;

  ring_pixel_board ring_board = new;
  int unsigned directed_frames;

  voice_ring_led_renderer #(
    .SINE_TABLE_DEPTH(SineDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .level_norm_i (level_norm_i),
    .time_ms_i    (time_ms_i),
    .pixel_valid_o(pixel_valid_o),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_level_o(pixel_level_o),
    .last_pixel_o (last_pixel_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && pixel_valid_o) begin
      ring_board.check_pixel(pixel_x_o, pixel_y_o, pixel_level_o, last_pixel_o);
    end
  end

  task automatic send_frame(logic [7:0] lvl, logic [31:0] tms);
    start_i = 1'b1;
    level_norm_i = lvl;
    time_ms_i = tms;
    do @(posedge clk_i); while (busy_o);
    ring_board.note_frame(lvl, tms);
    @(negedge clk_i);
  endtask

  task automatic hold_off(int unsigned cycles);
    start_i = 1'b0;
    level_norm_i = 8'($urandom);
    time_ms_i = $urandom;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start_i = 1'b0;
    while (ring_board.pending_pixels.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [7:0]  dir_levels[20];
    logic [31:0] dir_times[20];
    logic [7:0]  lvl;
    logic [31:0] tms;
    dir_levels = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd254,
                   8'd128, 8'd127, 8'h55, 8'hAA, 8'd64, 8'd192, 8'd255, 8'd0, 8'd200, 8'd30};
    dir_times = '{32'd0, 32'd0, 32'd507, 32'd507, 32'd1013, 32'd1013, 32'd1520, 32'd1520,
                  32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h55555555,
                  32'hAAAAAAAA, 32'd253, 32'd760, 32'd2027, 32'd2027, 32'd1, 32'hFFFFF000};
    start_i = 1'b0;
    level_norm_i = 8'd0;
    time_ms_i = 32'd0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_levels[i]) begin
      send_frame(dir_levels[i], dir_times[i]);
      directed_frames++;
    end
    wait_drained();

    for (int i = 0; i < RandomFrames; i++) begin
      case ($urandom_range(0, 7))
        0: lvl = 8'd0;
        1: lvl = 8'd255;
        default: lvl = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 3))
        0: tms = $urandom_range(0, 5000);
        1: tms = 32'hFFFFFFFF - $urandom_range(0, 5000);
        default: tms = $urandom;
      endcase
      if (i == RandomFrames / 2) begin
        wait_drained();
      end
      if (i < RandomFrames - CalmFrames && $urandom_range(0, 2) == 0) begin
        hold_off($urandom_range(1, 15));
      end
      send_frame(lvl, tms);
    end

    wait_drained();
    repeat (30) @(posedge clk_i);
    $display("Ran %0d frames (%0d directed) covering level and timestamp extremes and all phases;",
             ring_board.frames, directed_frames);
    $display("%0d pixels compared, %0d mismatches.", ring_board.checked_pixels,
             ring_board.mismatches);
    if (ring_board.mismatches == 0 && ring_board.pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d pixels outstanding.", ring_board.pending_pixels.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
